>>> hdl/set_assoc_cache_lru_tags_macros.svh
// assertion macros for the cache tag store checker
`ifndef SET_ASSOC_CACHE_LRU_TAGS_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_TAGS_MACROS_SVH

// clocked check, off while reset is low
`define SACL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sacl check failed");

// clocked check that also holds during reset
`define SACL_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sacl check failed");

`endif

>>> hdl/sacl_pkg.sv
package sacl_pkg;

    localparam int MAX_SET_BITS_DEF = 8;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_W           = 32;
    localparam int TAG_W            = 32;
    localparam int STAMP_W          = 32;
    localparam int CNT_W            = 32;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 5;

    // register reset values
    localparam logic [3:0] SET_BITS_RST   = 4'd4;
    localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
    localparam logic [3:0] WAYS_RST       = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS    = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_WAYS        = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_STORE  = 2'd1,
        CMD_MODIFY = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic             hit_flag;
        logic             miss_flag;
        logic             evict_flag;
        logic             extra_hit;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] evict_total;
    } t_rsp;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_line;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOKUP,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic read;
        logic lookup;
        logic scan;
        logic commit;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic need_scan;
        logic scan_last;
    } t_stat;

endpackage

>>> hdl/sacl_ctrl.sv
module sacl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  sacl_pkg::t_stat i_stat,
    output sacl_pkg::t_ctrl o_ctrl,
    output logic           o_busy
);

    sacl_pkg::t_state r_state;
    sacl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sacl_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_busy  = 1'b1;
        case (r_state)
            sacl_pkg::ST_CLEAR: begin
                o_ctrl.clear = 1'b1;
                if (i_stat.clear_last) n_state = sacl_pkg::ST_IDLE;
            end
            sacl_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = sacl_pkg::ST_READ;
                end
            end
            sacl_pkg::ST_READ: begin
                o_ctrl.read = 1'b1;
                n_state     = sacl_pkg::ST_LOOKUP;
            end
            sacl_pkg::ST_LOOKUP: begin
                o_ctrl.lookup = 1'b1;
                n_state = i_stat.need_scan ? sacl_pkg::ST_SCAN : sacl_pkg::ST_COMMIT;
            end
            sacl_pkg::ST_SCAN: begin
                o_ctrl.scan = 1'b1;
                if (i_stat.scan_last) n_state = sacl_pkg::ST_COMMIT;
            end
            sacl_pkg::ST_COMMIT: begin
                o_ctrl.commit = 1'b1;
                n_state       = sacl_pkg::ST_IDLE;
            end
            default: begin
                n_state = sacl_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

>>> hdl/sacl_datapath.sv
module sacl_datapath #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sacl_pkg::t_ctrl                     i_ctrl,
    input  sacl_pkg::t_req                      i_req,
    input  logic                                i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output sacl_pkg::t_stat                     o_stat,
    output logic                                o_done,
    output sacl_pkg::t_rsp                      o_result
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_IW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_CW   = $clog2(MAX_WAYS + 1);

    typedef sacl_pkg::t_line [MAX_WAYS-1:0] t_row;

    function automatic logic [sacl_pkg::CNT_W-1:0] sat_inc(
        input logic [sacl_pkg::CNT_W-1:0] v,
        input logic                       en
    );
        sat_inc = (en && (v != '1)) ? v + 1'b1 : v;
    endfunction

    // configuration registers
    logic [3:0] r_cfg_sets;
    logic [4:0] r_cfg_off;
    logic [3:0] r_cfg_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sets <= sacl_pkg::SET_BITS_RST;
            r_cfg_off  <= sacl_pkg::OFFSET_BITS_RST;
            r_cfg_ways <= sacl_pkg::WAYS_RST;
        end else if (i_cfg_we) begin
            case (sacl_pkg::t_cfg_idx'(i_cfg_idx))
                sacl_pkg::CFG_SET_BITS:    r_cfg_sets <= i_cfg_data[3:0];
                sacl_pkg::CFG_OFFSET_BITS: r_cfg_off  <= i_cfg_data;
                sacl_pkg::CFG_WAYS:        r_cfg_ways <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // address split for the incoming request
    logic [3:0]                 sbits;
    logic [5:0]                 tag_shift;
    logic [sacl_pkg::ADDR_W-1:0] shifted;
    logic [sacl_pkg::ADDR_W-1:0] set_full;
    logic [sacl_pkg::TAG_W-1:0]  tag_in;
    logic [4:0]                 ways_ext;
    logic [4:0]                 ways_clamp;

    always_comb begin
        sbits     = (r_cfg_sets > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : r_cfg_sets;
        shifted   = i_req.address >> r_cfg_off;
        set_full  = shifted & ~({sacl_pkg::ADDR_W{1'b1}} << sbits);
        tag_shift = {1'b0, r_cfg_off} + {2'b00, sbits};
        tag_in    = (tag_shift >= 6'(sacl_pkg::ADDR_W)) ? '0
                  : sacl_pkg::TAG_W'(i_req.address >> tag_shift);
        ways_ext  = {1'b0, r_cfg_ways};
        if (ways_ext == 5'd0) begin
            ways_clamp = 5'd1;
        end else if (ways_ext > 5'(MAX_WAYS)) begin
            ways_clamp = 5'(MAX_WAYS);
        end else begin
            ways_clamp = ways_ext;
        end
    end

    // request registers
    sacl_pkg::t_cmd               r_cmd;
    logic [SET_AW-1:0]            r_set;
    logic [sacl_pkg::TAG_W-1:0]   r_tag;
    logic [WAY_CW-1:0]            r_ways;
    logic [sacl_pkg::STAMP_W-1:0] r_clock;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_req.cmd;
            r_set  <= set_full[SET_AW-1:0];
            r_tag  <= tag_in;
            r_ways <= WAY_CW'(ways_clamp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
        end else if (i_ctrl.load) begin
            r_clock <= r_clock + 1'b1;
        end
    end

    // tag store, one row per set
    t_row              r_mem [NUM_SETS];
    t_row              r_rdata;
    t_row              wr_row;
    logic              mem_we;
    logic [SET_AW-1:0] mem_waddr;
    t_row              mem_wdata;
    logic [SET_AW-1:0] r_clr_cnt;
    logic              noop;

    logic              r_hit;
    logic              r_miss;
    logic              r_evict;
    logic [WAY_IW-1:0] r_pick;

    assign noop = (r_cmd == sacl_pkg::CMD_NONE);

    always_comb begin
        wr_row = r_rdata;
        wr_row[r_pick].stamp = r_clock;
        if (r_miss) begin
            wr_row[r_pick].valid = 1'b1;
            wr_row[r_pick].tag   = r_tag;
        end
        mem_we    = i_ctrl.clear || (i_ctrl.commit && !noop);
        mem_waddr = i_ctrl.clear ? r_clr_cnt : r_set;
        mem_wdata = i_ctrl.clear ? t_row'('0) : wr_row;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (i_ctrl.read) r_rdata <= r_mem[r_set];
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_ctrl.clear) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // parallel tag compare and first free way
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] free_vec;
    logic [WAY_IW-1:0]   hit_way;
    logic [WAY_IW-1:0]   free_way;
    logic                found;
    logic                has_free;

    always_comb begin
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            hit_vec[w]  = (WAY_CW'(w) < r_ways) && r_rdata[w].valid
                       && (r_rdata[w].tag == r_tag);
            free_vec[w] = (WAY_CW'(w) < r_ways) && !r_rdata[w].valid;
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w])  hit_way  = WAY_IW'(w);
            if (free_vec[w]) free_way = WAY_IW'(w);
        end
        found    = |hit_vec;
        has_free = |free_vec;
    end

    // victim scan, one way per cycle
    logic [WAY_IW-1:0]            r_way;
    logic [sacl_pkg::STAMP_W-1:0] r_best;
    logic [sacl_pkg::STAMP_W-1:0] age;

    assign age = r_clock - r_rdata[r_way].stamp;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.lookup) begin
            r_hit   <= found && !noop;
            r_miss  <= !found && !noop;
            r_evict <= !found && !has_free && !noop;
            r_pick  <= found ? hit_way : free_way;
            r_way   <= '0;
        end else if (i_ctrl.scan) begin
            if ((r_way == '0) || (age > r_best)) begin
                r_best <= age;
                r_pick <= r_way;
            end
            r_way <= r_way + 1'b1;
        end
    end

    // counters and result
    logic [sacl_pkg::CNT_W-1:0] r_hit_cnt;
    logic [sacl_pkg::CNT_W-1:0] r_miss_cnt;
    logic [sacl_pkg::CNT_W-1:0] r_evict_cnt;
    logic [sacl_pkg::CNT_W-1:0] n_hit_cnt;
    logic [sacl_pkg::CNT_W-1:0] n_miss_cnt;
    logic [sacl_pkg::CNT_W-1:0] n_evict_cnt;
    logic                       extra;
    logic                       r_done;
    sacl_pkg::t_rsp             r_result;

    always_comb begin
        extra       = (r_cmd == sacl_pkg::CMD_MODIFY);
        n_hit_cnt   = sat_inc(sat_inc(r_hit_cnt, r_hit), extra);
        n_miss_cnt  = sat_inc(r_miss_cnt, r_miss);
        n_evict_cnt = sat_inc(r_evict_cnt, r_evict);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_ctrl.commit;
            if (i_ctrl.commit) begin
                r_hit_cnt   <= n_hit_cnt;
                r_miss_cnt  <= n_miss_cnt;
                r_evict_cnt <= n_evict_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit) begin
            r_result.hit_flag    <= r_hit;
            r_result.miss_flag   <= r_miss;
            r_result.evict_flag  <= r_evict;
            r_result.extra_hit   <= extra;
            r_result.hit_total   <= n_hit_cnt;
            r_result.miss_total  <= n_miss_cnt;
            r_result.evict_total <= n_evict_cnt;
        end
    end

    always_comb begin
        o_stat.clear_last = (r_clr_cnt == SET_AW'(NUM_SETS - 1));
        o_stat.need_scan  = !found && !has_free && !noop;
        o_stat.scan_last  = (WAY_CW'(r_way) == r_ways - 1'b1);
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> hdl/set_assoc_cache_lru_tags.sv
// tag store of a set-associative cache with lru replacement. pulse start while busy
// is low to issue one request (cmd, address); the request is taken at that edge. the
// result appears on o_result for exactly one cycle with o_done high; the receiver
// cannot stall, so it must take it then. a hit, a fill of a free way or an unused
// command goes through accept, row read, tag compare and write-back before the next
// accept; a miss that evicts adds a stamp scan between compare and write-back that
// visits one way per cycle to find the oldest line, over the ways in use once the
// ways setting is clamped to 1..MAX_WAYS. after reset the tag store is swept clear,
// one set row per cycle, over all 2^MAX_SET_BITS rows with busy high; configuration
// writes are taken at any time, but only change behavior cleanly while busy is low
// and no result is pending.
module set_assoc_cache_lru_tags #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            start,
    output logic                            busy,
    input  sacl_pkg::t_req                  i_req,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // result channel, one strobe per request
    output logic                            o_done,
    output sacl_pkg::t_rsp                  o_result
);

    sacl_pkg::t_ctrl ctrl;
    sacl_pkg::t_stat stat;

    // sequencer: clear sweep, accept, read, compare, optional scan, write-back
    sacl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    // address split, set row memory, compare, victim scan and counters
    sacl_datapath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

>>> hdl/sacl_checker.sv
`include "set_assoc_cache_lru_tags_macros.svh"

module sacl_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input sacl_pkg::t_rsp o_result
);

    // an accepted request keeps the block busy in the next cycle
    `SACL_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy)

    // a result only follows a busy cycle
    `SACL_ASSERT(a_done_after_busy, i_clk, i_rst_n, o_done |-> $past(busy))

    // hit and miss exclude each other
    `SACL_ASSERT(a_excl, i_clk, i_rst_n, o_done |-> !(o_result.hit_flag && o_result.miss_flag))

    // an eviction is a miss
    `SACL_ASSERT(a_evict, i_clk, i_rst_n, o_done && o_result.evict_flag |-> o_result.miss_flag)

    // no result strobe while reset is applied
    `SACL_ASSERT_ALWAYS(a_no_done_in_reset, i_clk, !i_rst_n |=> !o_done)

endmodule

bind set_assoc_cache_lru_tags sacl_checker u_sacl_checker (.*);

>>> tb/set_assoc_cache_lru_tags_test.sv
`timescale 1ns / 1ps

module set_assoc_cache_lru_tags_test;

    // cycles with no request taken, no result and no register write before giving up;
    // covers the clear sweep after reset (256 rows) with plenty of margin
    localparam int QUIET_LIMIT = 3000;
    localparam int NUM_SETS    = 1 << sacl_pkg::MAX_SET_BITS_DEF;
    localparam int NUM_LINES   = NUM_SETS * sacl_pkg::MAX_WAYS_DEF;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 86;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    sacl_pkg::t_req i_req = '0;
    logic i_cfg_we = 1'b0;
    logic [sacl_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic busy;
    logic o_done;
    sacl_pkg::t_rsp o_result;

    // requests waiting to go out, and results the tag store is expected to produce
    sacl_pkg::t_req pending_requests[$];
    sacl_pkg::t_rsp expected_results[$];

    int idle_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;
    logic [31:0] tag_base = '0;

    // shadow copy of the tag store: one row of MAX_WAYS lines per set
    logic        shadow_valid [NUM_LINES];
    logic [31:0] shadow_tag   [NUM_LINES];
    logic [31:0] shadow_stamp [NUM_LINES];
    logic [31:0] use_clock   = '0;
    logic [31:0] hit_count   = '0;
    logic [31:0] miss_count  = '0;
    logic [31:0] evict_count = '0;

    // shadow copies of the geometry registers, as written (not yet clamped)
    logic [3:0] set_bits_reg    = sacl_pkg::SET_BITS_RST;
    logic [4:0] offset_bits_reg = sacl_pkg::OFFSET_BITS_RST;
    logic [3:0] ways_reg        = sacl_pkg::WAYS_RST;

    set_assoc_cache_lru_tags dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < NUM_LINES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_tag[i]   = '0;
            shadow_stamp[i] = '0;
        end
    end

    // counters stick at all ones
    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // clamped geometry as the lookup uses it
    function automatic int unsigned eff_set_bits();
        return (set_bits_reg > sacl_pkg::MAX_SET_BITS_DEF) ? sacl_pkg::MAX_SET_BITS_DEF
                                                             : set_bits_reg;
    endfunction

    function automatic int unsigned eff_ways();
        if (ways_reg == 0)
            return 1;
        return (ways_reg > sacl_pkg::MAX_WAYS_DEF) ? sacl_pkg::MAX_WAYS_DEF : ways_reg;
    endfunction

    // one lookup of the tag store: hit, fill of the lowest free way, or lru eviction
    task automatic predict_access(input sacl_pkg::t_req rq, output sacl_pkg::t_rsp rs);
        int unsigned sb;
        int unsigned ob;
        int unsigned nw;
        int unsigned base;
        int unsigned pick;
        logic [63:0] a64;
        logic [63:0] set_idx;
        logic [31:0] tag;
        logic [31:0] age;
        logic [31:0] oldest;
        bit found;
        bit spare;
        rs = '0;
        use_clock = use_clock + 32'd1;
        if (rq.cmd != sacl_pkg::CMD_NONE) begin
            sb = eff_set_bits();
            ob = offset_bits_reg;
            nw = eff_ways();
            a64 = {32'b0, rq.address};
            set_idx = (a64 >> ob) & ((64'd1 << sb) - 64'd1);
            // offset plus set bits can run past the address: tag becomes zero
            tag = 32'(a64 >> (ob + sb));
            base = int'(set_idx[7:0]) * sacl_pkg::MAX_WAYS_DEF;
            pick = 0;
            found = 1'b0;
            for (int w = 0; w < nw && !found; w++) begin
                if (shadow_valid[base + w] && shadow_tag[base + w] == tag) begin
                    pick = w;
                    found = 1'b1;
                end
            end
            if (found) begin
                rs.hit_flag = 1'b1;
            end else begin
                spare = 1'b0;
                for (int w = 0; w < nw && !spare; w++) begin
                    if (!shadow_valid[base + w]) begin
                        pick = w;
                        spare = 1'b1;
                    end
                end
                if (!spare) begin
                    // oldest stamp wins, ties go to the lowest way
                    oldest = '0;
                    pick = 0;
                    for (int w = 0; w < nw; w++) begin
                        age = use_clock - shadow_stamp[base + w];
                        if (w == 0 || age > oldest) begin
                            oldest = age;
                            pick = w;
                        end
                    end
                    rs.evict_flag = 1'b1;
                end
                rs.miss_flag = 1'b1;
                shadow_valid[base + pick] = 1'b1;
                shadow_tag[base + pick] = tag;
            end
            shadow_stamp[base + pick] = use_clock;
            // a modify's second touch always lands on the same line
            rs.extra_hit = (rq.cmd == sacl_pkg::CMD_MODIFY);
            if (rs.hit_flag)
                hit_count = bump(hit_count);
            if (rs.miss_flag)
                miss_count = bump(miss_count);
            if (rs.evict_flag)
                evict_count = bump(evict_count);
            if (rs.extra_hit)
                hit_count = bump(hit_count);
        end
        rs.hit_total = hit_count;
        rs.miss_total = miss_count;
        rs.evict_total = evict_count;
    endtask

    // request driver: holds start until the request is taken, idles at random
    always @(posedge i_clk) begin
        sacl_pkg::t_rsp predicted;
        logic issue;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            issue = start;
            if (start && !busy) begin
                predict_access(i_req, predicted);
                expected_results.push_back(predicted);
                issue = 1'b0;
            end
            if (!issue && pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_req <= pending_requests.pop_front();
                issue = 1'b1;
            end
            start <= issue;
        end
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // result monitor: every strobe must match the oldest outstanding prediction
    always @(posedge i_clk) begin
        sacl_pkg::t_rsp want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_result);
                errors++;
            end else begin
                want = expected_results.pop_front();
                report_field("hit_flag", want.hit_flag, o_result.hit_flag);
                report_field("miss_flag", want.miss_flag, o_result.miss_flag);
                report_field("evict_flag", want.evict_flag, o_result.evict_flag);
                report_field("extra_hit", want.extra_hit, o_result.extra_hit);
                report_field("hit_total", want.hit_total, o_result.hit_total);
                report_field("miss_total", want.miss_total, o_result.miss_total);
                report_field("evict_total", want.evict_total, o_result.evict_total);
            end
        end
    end

    // watchdog: too long with nothing moving means the block hung
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_request(input sacl_pkg::t_cmd c, input logic [31:0] a);
        sacl_pkg::t_req rq;
        rq.cmd = c;
        rq.address = a;
        pending_requests.push_back(rq);
    endtask

    // wait until every request is out, every result is back and the block is idle;
    // sampled mid-cycle so the driver's updates at the clock edge have settled
    task automatic drain();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || start || expected_results.size() != 0 || busy)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write; the shadow copy is updated at once since nothing is in flight
    task automatic write_reg(input sacl_pkg::t_cfg_idx idx, input logic [4:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            sacl_pkg::CFG_SET_BITS:    set_bits_reg = data[3:0];
            sacl_pkg::CFG_OFFSET_BITS: offset_bits_reg = data;
            sacl_pkg::CFG_WAYS:        ways_reg = data[3:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly addresses that reuse a few tags in a few sets so that hits and
    // evictions are common; the rest are fully random
    function automatic logic [31:0] pick_address();
        int unsigned sb;
        int unsigned ob;
        logic [63:0] a64;
        logic [63:0] tag;
        logic [63:0] set_idx;
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        sb = eff_set_bits();
        ob = offset_bits_reg;
        tag = {32'b0, tag_base + 32'($urandom_range(0, eff_ways() + 1))};
        set_idx = 64'($urandom_range(0, 3)) & ((64'd1 << sb) - 64'd1);
        a64 = (tag << (ob + sb)) | (set_idx << ob) | (64'($urandom) & ((64'd1 << ob) - 64'd1));
        return a64[31:0];
    endfunction

    function automatic sacl_pkg::t_cmd pick_cmd();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 5)
            return sacl_pkg::CMD_LOAD;
        if (r < 10)
            return sacl_pkg::CMD_STORE;
        if (r < 15)
            return sacl_pkg::CMD_MODIFY;
        return sacl_pkg::CMD_NONE;
    endfunction

    // geometry and sender idling per random phase; a few values lie outside the
    // legal range (or carry spare high bits) to hit the clamping
    logic [4:0] phase_set_bits [RANDOM_PHASES] = '{5'd0, 5'd8, 5'd3, 5'd31, 5'd2, 5'd8, 5'd5, 5'd1};
    logic [4:0] phase_offset   [RANDOM_PHASES] = '{5'd0, 5'd23, 5'd5, 5'd31, 5'd6, 5'd4, 5'd12, 5'd2};
    logic [4:0] phase_ways     [RANDOM_PHASES] = '{5'd1, 5'd8, 5'd4, 5'd31, 5'd0, 5'd8, 5'd3, 5'd2};
    int         phase_idle     [RANDOM_PHASES] = '{0, 54, 0, 27, 54, 27, 0, 54};

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // let the clear sweep finish
        @(posedge i_clk);
        drain();

        // directed part: two sets, two ways
        write_reg(sacl_pkg::CFG_SET_BITS, 5'd1);
        write_reg(sacl_pkg::CFG_OFFSET_BITS, 5'd4);
        write_reg(sacl_pkg::CFG_WAYS, 5'd2);
        idle_pct = 0;
        queue_request(sacl_pkg::CMD_LOAD,   32'h0000_0000);  // cold miss, fills way 0
        queue_request(sacl_pkg::CMD_LOAD,   32'h0000_0004);  // same block, hit
        queue_request(sacl_pkg::CMD_STORE,  32'h0000_0100);  // same set, fills way 1
        queue_request(sacl_pkg::CMD_MODIFY, 32'h0000_0000);  // modify that hits
        queue_request(sacl_pkg::CMD_LOAD,   32'h0000_0200);  // set full, evicts the older line
        queue_request(sacl_pkg::CMD_MODIFY, 32'hFFFF_FFFF);  // modify after a miss, top address
        queue_request(sacl_pkg::CMD_LOAD,   32'hFFFF_FFF0);  // hit on the line just filled
        queue_request(sacl_pkg::CMD_NONE,   32'h1234_5678);  // unused command touches nothing
        queue_request(sacl_pkg::CMD_NONE,   32'hFFFF_FFFF);
        queue_request(sacl_pkg::CMD_STORE,  32'h0000_0100);  // evicts again
        queue_request(sacl_pkg::CMD_LOAD,   32'h0000_0010);  // second way of the upper set
        queue_request(sacl_pkg::CMD_LOAD,   32'h8000_0000);
        queue_request(sacl_pkg::CMD_STORE,  32'h7FFF_FFFF);
        queue_request(sacl_pkg::CMD_MODIFY, 32'h8000_0000);
        queue_request(sacl_pkg::CMD_LOAD,   32'h0000_0000);
        queue_request(sacl_pkg::CMD_LOAD,   32'hAAAA_AAAA);
        queue_request(sacl_pkg::CMD_STORE,  32'h5555_5555);
        drain();

        // unused register index must change nothing
        write_reg(sacl_pkg::CFG_UNUSED, 5'($urandom));

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_reg(sacl_pkg::CFG_SET_BITS, phase_set_bits[p]);
            write_reg(sacl_pkg::CFG_OFFSET_BITS, phase_offset[p]);
            write_reg(sacl_pkg::CFG_WAYS, phase_ways[p]);
            idle_pct = phase_idle[p];
            tag_base = $urandom;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                queue_request(pick_cmd(), pick_address());
            drain();
        end

        // longest request is an evicting miss over every way; leave room for strays
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
